FILE: rtl/core/starfield_parallax_scroller_unit_macros.svh
// assertion macros shared by the starfield scroller rtl
// expects clk and rst_n in the scope of each use
`ifndef STARFIELD_PARALLAX_SCROLLER_UNIT_MACROS_SVH
`define STARFIELD_PARALLAX_SCROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define SFPS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfps assertion failed");

// next-cycle implication
`define SFPS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfps assertion failed");

// invariant
`define SFPS_ASSERT_ALW(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("sfps assertion failed");

`endif

FILE: rtl/core/sfps_pkg.sv
// types, codes and constants of the starfield scroller
// no dependencies
package sfps_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 13;
    localparam int DIV_CNT_W  = 5;

    localparam logic [31:0] LFSR_TAPS  = 32'h8020_0003;
    localparam logic [31:0] LFSR_RESET = 32'h0000_0001;

    localparam logic [1:0] CMD_SEED   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_PLOT   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FIELD_HEIGHT = 3'd1;
    localparam logic [2:0] REG_ACTIVE_STARS = 3'd2;
    localparam logic [2:0] REG_DEPTH_LEVELS = 3'd3;
    localparam logic [2:0] REG_FIRST_COLOR  = 3'd4;
    localparam logic [2:0] REG_LAST_COLOR   = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COLOR,
        ST_SEED_X,
        ST_SEED_Y,
        ST_SEED_Z,
        ST_SEED_WR,
        ST_DRAW,
        ST_SCR_RD,
        ST_SCR_CALC,
        ST_CHK_XL,
        ST_CHK_YL,
        ST_CHK_XH,
        ST_CHK_YH,
        ST_SCR_WR,
        ST_PLOT_RD,
        ST_PLOT_OUT
    } state_t;

    typedef enum logic [1:0] {
        DST_X,
        DST_Y,
        DST_Z,
        DST_COLOR
    } dest_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

    // galois lfsr, right shift
    function automatic logic [31:0] lfsr_step(input logic [31:0] s);
        logic [31:0] n;
        n = {1'b0, s[31:1]};
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/starfield_parallax_scroller_unit.sv
// top level of the parallax starfield scroller
// depends on sfps_pkg, sfps_ram, sfps_divider and the assertion macro header
//
// usage:
//  - input channel (in_valid / in_stall) carries one command word: cmd, x_step,
//    y_step, star_index, x_origin, y_origin. a word is taken when in_valid is
//    high and in_stall low; in_stall stays high while a command is running
//  - output channel (out_valid / out_stall) carries pixel_x, pixel_y,
//    pixel_color, one word per plot command with an index below the active count
//  - apb port holds six registers at byte addresses 0, 4, ... 20; pready is
//    always high; write them only while the block is idle
//  - seed: a serial division for the color step, then per star three
//    random draws plus a write, over all MAX_STARS entries
//  - scroll: per active star a read, the sum, the edge tests and a write;
//    each edge wrap adds a random draw that the serial divider reduces
//  - plot: star read, then the result word goes to the output register when free
//  - the output register holds a result while out_stall is high; the next
//    word is accepted meanwhile, a following plot waits for the register
//  - reset: registers take their defaults, color step 0, lfsr 1; the star
//    memory holds nothing until a seed command fills it
`include "starfield_parallax_scroller_unit_macros.svh"

module starfield_parallax_scroller_unit #(
    parameter int MAX_STARS  = 1024,
    parameter int MAX_DEPTH  = 16,
    parameter int COORD_BITS = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    // apb configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // command words
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] x_step,
    input  logic signed [15:0] y_step,
    input  logic [9:0]         star_index,
    input  logic signed [11:0] x_origin,
    input  logic signed [11:0] y_origin,
    // result words
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [12:0] pixel_x,
    output logic signed [12:0] pixel_y,
    output logic [7:0]         pixel_color
);
    import sfps_pkg::*;

    localparam int POS_W   = COORD_BITS + 8;
    localparam int DEPTH_W = $clog2(MAX_DEPTH);
    localparam int LV_W    = $clog2(MAX_DEPTH + 1);
    localparam int W_W     = COORD_BITS + 1;
    localparam int CNT_W   = $clog2(MAX_STARS + 1);
    localparam int ADDR_W  = (MAX_STARS > 1) ? $clog2(MAX_STARS) : 1;
    localparam int PROD_W  = LV_W + 17;
    localparam int SUM_W   = ((POS_W > PROD_W) ? POS_W : PROD_W) + 2;
    localparam int ENTRY_W = 2 * POS_W + DEPTH_W;

    // configuration registers
    logic [10:0] field_width_reg;
    logic [10:0] field_height_reg;
    logic [10:0] active_stars_reg;
    logic [4:0]  depth_levels_reg;
    logic [7:0]  first_color_reg;
    logic [7:0]  last_color_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg  <= 11'd320;
            field_height_reg <= 11'd200;
            active_stars_reg <= 11'd256;
            depth_levels_reg <= 5'd8;
            first_color_reg  <= 8'd255;
            last_color_reg   <= 8'd0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_FIELD_WIDTH:  field_width_reg  <= pwdata[10:0];
                REG_FIELD_HEIGHT: field_height_reg <= pwdata[10:0];
                REG_ACTIVE_STARS: active_stars_reg <= pwdata[10:0];
                REG_DEPTH_LEVELS: depth_levels_reg <= pwdata[4:0];
                REG_FIRST_COLOR:  first_color_reg  <= pwdata[7:0];
                REG_LAST_COLOR:   last_color_reg   <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_FIELD_WIDTH:  prdata = 32'(field_width_reg);
            REG_FIELD_HEIGHT: prdata = 32'(field_height_reg);
            REG_ACTIVE_STARS: prdata = 32'(active_stars_reg);
            REG_DEPTH_LEVELS: prdata = 32'(depth_levels_reg);
            REG_FIRST_COLOR:  prdata = 32'(first_color_reg);
            REG_LAST_COLOR:   prdata = 32'(last_color_reg);
            default:          prdata = 32'd0;
        endcase
    end

    // effective ranges: zero counts as one (but for the star count), oversized values saturate
    logic [W_W-1:0]   eff_w, eff_h;
    logic [LV_W-1:0]  eff_lv;
    logic [CNT_W-1:0] eff_n;

    always_comb
    begin
        if (field_width_reg == 11'd0)
            eff_w = W_W'(1);
        else if (13'(field_width_reg) > 13'(1 << COORD_BITS))
            eff_w = W_W'(1 << COORD_BITS);
        else
            eff_w = W_W'(field_width_reg);
        if (field_height_reg == 11'd0)
            eff_h = W_W'(1);
        else if (13'(field_height_reg) > 13'(1 << COORD_BITS))
            eff_h = W_W'(1 << COORD_BITS);
        else
            eff_h = W_W'(field_height_reg);
        if (depth_levels_reg == 5'd0)
            eff_lv = LV_W'(1);
        else if (7'(depth_levels_reg) > 7'(MAX_DEPTH))
            eff_lv = LV_W'(MAX_DEPTH);
        else
            eff_lv = LV_W'(depth_levels_reg);
        if (13'(active_stars_reg) > 13'(MAX_STARS))
            eff_n = CNT_W'(MAX_STARS);
        else
            eff_n = CNT_W'(active_stars_reg);
    end

    // sequencer state
    state_t               state_reg, state_next;
    state_t               ret_reg, ret_next;
    dest_t                dest_reg, dest_next;
    logic [31:0]          lfsr_reg, lfsr_next;
    logic signed [8:0]    color_step_reg, color_step_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 out_valid_reg, out_valid_next;

    // working registers of the current item and star
    logic signed [SUM_W-1:0] x_reg, x_next;
    logic signed [SUM_W-1:0] y_reg, y_next;
    logic [DEPTH_W-1:0]      z_reg, z_next;
    logic signed [15:0]      xs_reg, xs_next;
    logic signed [15:0]      ys_reg, ys_next;
    logic [9:0]              sidx_reg, sidx_next;
    logic signed [11:0]      xo_reg, xo_next;
    logic signed [11:0]      yo_reg, yo_next;
    logic signed [12:0]      px_reg, px_next;
    logic signed [12:0]      py_reg, py_next;
    logic [7:0]              pc_reg, pc_next;

    // shared divider and star memory
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

    sfps_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    sfps_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (MAX_STARS),
        .ADDR_W (ADDR_W)
    ) u_star_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // fields of the stored star
    logic [POS_W-1:0]   rd_x, rd_y;
    logic [DEPTH_W-1:0] rd_z;

    assign rd_x = mem_rdata[POS_W-1:0];
    assign rd_y = mem_rdata[2*POS_W-1:POS_W];
    assign rd_z = mem_rdata[ENTRY_W-1:2*POS_W];

    // scroll arithmetic: position plus (depth + 1) times step
    logic [LV_W-1:0]          z_inc;
    logic signed [PROD_W-1:0] x_prod, y_prod;
    logic signed [SUM_W-1:0]  wq, hq;

    assign z_inc  = LV_W'(rd_z) + LV_W'(1);
    assign x_prod = $signed({1'b0, z_inc}) * xs_reg;
    assign y_prod = $signed({1'b0, z_inc}) * ys_reg;
    assign wq     = $signed(SUM_W'({eff_w, 8'h00}));
    assign hq     = $signed(SUM_W'({eff_h, 8'h00}));

    // color step: (|last - first| + 1) / levels with the sign of the slope
    logic [8:0] color_mag;
    logic [8:0] quo9;

    assign color_mag = (last_color_reg >= first_color_reg)
                     ? 9'(last_color_reg - first_color_reg) + 9'd1
                     : 9'(first_color_reg - last_color_reg) + 9'd1;
    assign quo9      = div_rsp.quotient[8:0];

    // plot arithmetic
    logic [7:0]  factor;
    logic [15:0] color_prod;

    assign factor     = 8'(eff_lv) - 8'd1 - 8'(rd_z);
    assign color_prod = factor * color_step_reg[7:0];

    logic in_acc, out_free, out_load;

    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            dest_reg       <= DST_X;
            lfsr_reg       <= LFSR_RESET;
            color_step_reg <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            dest_reg       <= dest_next;
            lfsr_reg       <= lfsr_next;
            color_step_reg <= color_step_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        xs_reg   <= xs_next;
        ys_reg   <= ys_next;
        sidx_reg <= sidx_next;
        xo_reg   <= xo_next;
        yo_reg   <= yo_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        pc_reg   <= pc_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        dest_next       = dest_reg;
        lfsr_next       = lfsr_reg;
        color_step_next = color_step_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        xs_next         = xs_reg;
        ys_next         = ys_reg;
        sidx_next       = sidx_reg;
        xo_next         = xo_reg;
        yo_next         = yo_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pc_next         = pc_reg;
        div_req         = '0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = idx_reg[ADDR_W-1:0];
        mem_raddr       = idx_reg[ADDR_W-1:0];
        mem_wdata       = {z_reg, y_reg[POS_W-1:0], x_reg[POS_W-1:0]};
        out_load        = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    xs_next   = x_step;
                    ys_next   = y_step;
                    sidx_next = star_index;
                    xo_next   = x_origin;
                    yo_next   = y_origin;
                    idx_next  = '0;
                    case (cmd)
                        CMD_SEED:   state_next = ST_COLOR;
                        CMD_SCROLL: state_next = ST_SCR_RD;
                        CMD_PLOT:
                        begin
                            // index at or beyond the active count gives no word
                            if (13'(star_index) < 13'(eff_n))
                                state_next = ST_PLOT_RD;
                        end
                        default:    ;
                    endcase
                end
            end

            ST_COLOR:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = DIVIDEND_W'(color_mag);
                div_req.divisor  = DIVISOR_W'(eff_lv);
                dest_next        = DST_COLOR;
                ret_next         = ST_SEED_X;
                state_next       = ST_DRAW;
            end

            ST_SEED_X:
            begin
                lfsr_next        = lfsr_step(lfsr_reg);
                div_req.start    = 1'b1;
                div_req.dividend = lfsr_next;
                div_req.divisor  = DIVISOR_W'(eff_w);
                dest_next        = DST_X;
                ret_next         = ST_SEED_Y;
                state_next       = ST_DRAW;
            end

            ST_SEED_Y:
            begin
                lfsr_next        = lfsr_step(lfsr_reg);
                div_req.start    = 1'b1;
                div_req.dividend = lfsr_next;
                div_req.divisor  = DIVISOR_W'(eff_h);
                dest_next        = DST_Y;
                ret_next         = ST_SEED_Z;
                state_next       = ST_DRAW;
            end

            ST_SEED_Z:
            begin
                lfsr_next        = lfsr_step(lfsr_reg);
                div_req.start    = 1'b1;
                div_req.dividend = lfsr_next;
                div_req.divisor  = DIVISOR_W'(eff_lv);
                dest_next        = DST_Z;
                ret_next         = ST_SEED_WR;
                state_next       = ST_DRAW;
            end

            ST_SEED_WR:
            begin
                mem_we = 1'b1;
                if (idx_reg == CNT_W'(MAX_STARS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SEED_X;
                end
            end

            // wait for the divider, then route its result
            ST_DRAW:
            begin
                if (div_rsp.done)
                begin
                    case (dest_reg)
                        DST_X: x_next = $signed(SUM_W'(
                                   {div_rsp.remainder[COORD_BITS-1:0], 8'h00}));
                        DST_Y: y_next = $signed(SUM_W'(
                                   {div_rsp.remainder[COORD_BITS-1:0], 8'h00}));
                        DST_Z: z_next = div_rsp.remainder[DEPTH_W-1:0];
                        DST_COLOR:
                        begin
                            color_step_next = (first_color_reg > last_color_reg)
                                            ? $signed(9'd0 - quo9) : $signed(quo9);
                        end
                        default: ;
                    endcase
                    state_next = ret_reg;
                end
            end

            ST_SCR_RD:
            begin
                if (idx_reg >= eff_n)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = ST_SCR_CALC;
                end
            end

            ST_SCR_CALC:
            begin
                x_next     = $signed(SUM_W'(rd_x)) + SUM_W'(x_prod);
                y_next     = $signed(SUM_W'(rd_y)) + SUM_W'(y_prod);
                z_next     = rd_z;
                state_next = ST_CHK_XL;
            end

            // edge tests in fixed order: x low, y low, x high, y high
            ST_CHK_XL:
            begin
                state_next = ST_CHK_YL;
                if (x_reg[SUM_W-1])
                begin
                    x_next           = $signed(SUM_W'({eff_w - W_W'(1), 8'h00}));
                    lfsr_next        = lfsr_step(lfsr_reg);
                    div_req.start    = 1'b1;
                    div_req.dividend = lfsr_next;
                    div_req.divisor  = DIVISOR_W'(eff_lv);
                    dest_next        = DST_Z;
                    ret_next         = ST_CHK_YL;
                    state_next       = ST_DRAW;
                end
            end

            ST_CHK_YL:
            begin
                state_next = ST_CHK_XH;
                if (y_reg[SUM_W-1])
                begin
                    y_next           = $signed(SUM_W'({eff_h - W_W'(1), 8'h00}));
                    lfsr_next        = lfsr_step(lfsr_reg);
                    div_req.start    = 1'b1;
                    div_req.dividend = lfsr_next;
                    div_req.divisor  = DIVISOR_W'(eff_lv);
                    dest_next        = DST_Z;
                    ret_next         = ST_CHK_XH;
                    state_next       = ST_DRAW;
                end
            end

            ST_CHK_XH:
            begin
                state_next = ST_CHK_YH;
                if (x_reg >= wq)
                begin
                    x_next           = '0;
                    lfsr_next        = lfsr_step(lfsr_reg);
                    div_req.start    = 1'b1;
                    div_req.dividend = lfsr_next;
                    div_req.divisor  = DIVISOR_W'(eff_lv);
                    dest_next        = DST_Z;
                    ret_next         = ST_CHK_YH;
                    state_next       = ST_DRAW;
                end
            end

            ST_CHK_YH:
            begin
                state_next = ST_SCR_WR;
                if (y_reg >= hq)
                begin
                    y_next           = '0;
                    lfsr_next        = lfsr_step(lfsr_reg);
                    div_req.start    = 1'b1;
                    div_req.dividend = lfsr_next;
                    div_req.divisor  = DIVISOR_W'(eff_lv);
                    dest_next        = DST_Z;
                    ret_next         = ST_SCR_WR;
                    state_next       = ST_DRAW;
                end
            end

            ST_SCR_WR:
            begin
                mem_we     = 1'b1;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SCR_RD;
            end

            ST_PLOT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(sidx_reg);
                state_next = ST_PLOT_OUT;
            end

            ST_PLOT_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    px_next        = 13'(xo_reg) + $signed(13'(rd_x[POS_W-1:8]));
                    py_next        = 13'(yo_reg) + $signed(13'(rd_y[POS_W-1:8]));
                    pc_next        = first_color_reg + color_prod[7:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign pixel_x     = px_reg;
    assign pixel_y     = py_reg;
    assign pixel_color = pc_reg;

    `SFPS_ASSERT_ALW(a_lfsr_nonzero, lfsr_reg != 32'd0)
    `SFPS_ASSERT_IMP(a_div_start_free, div_req.start, !div_rsp.busy)
    `SFPS_ASSERT_IMP(a_out_load_free, out_load, !out_valid_reg || !out_stall)

endmodule

FILE: rtl/core/sfps_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module sfps_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/sfps_divider.sv
// restoring serial divider, one quotient bit per cycle
// depends on sfps_pkg and the assertion macro header
`include "starfield_parallax_scroller_unit_macros.svh"

module sfps_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  sfps_pkg::div_req_t req,
    output sfps_pkg::div_rsp_t rsp
);
    import sfps_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    trial;
    logic                  ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    always_comb
    begin
        trial     = {rem_reg, work_reg[DIVIDEND_W-1]};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            work_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits
            rem_next  = ge ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            work_next = {work_reg[DIVIDEND_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = work_reg;
    assign rsp.remainder = rem_reg;

    `SFPS_ASSERT_NXT(a_div_start_busy, req.start, busy_reg)
    `SFPS_ASSERT_IMP(a_div_done_idle, done_reg, !busy_reg)
    `SFPS_ASSERT_NXT(a_div_done_pulse, done_reg && !req.start, !done_reg)

endmodule

FILE: bench/sfps_checker.sv
// scoreboard for the starfield scroller: snoops apb writes and both word channels
// keeps its own star table, lfsr and registers; depends on sfps_pkg
module sfps_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] x_step,
    input  logic signed [15:0] y_step,
    input  logic [9:0]         star_index,
    input  logic signed [11:0] x_origin,
    input  logic signed [11:0] y_origin,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [12:0] pixel_x,
    input  logic signed [12:0] pixel_y,
    input  logic [7:0]         pixel_color,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sfps_pkg::*;

    localparam int NSTARS = 1024;
    localparam int NDEPTH = 16;
    localparam int NCOORD = 1024;

    typedef struct {
        logic signed [12:0] px;
        logic signed [12:0] py;
        logic [7:0]         color;
    } pixel_t;

    pixel_t pixel_q[$];

    int          star_x[NSTARS];
    int          star_y[NSTARS];
    int unsigned star_z[NSTARS];
    logic signed [8:0] color_step;
    logic [31:0] lfsr;
    logic [10:0] fld_w, fld_h, n_active;
    logic [4:0]  n_levels;
    logic [7:0]  color_near, color_far;

    assign pending = pixel_q.size();

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned draw(int unsigned range);
        lfsr = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
        return lfsr % range;
    endfunction

    task automatic seed_field();
        int unsigned w, h, lv;
        int diff, mag, st;
        w = clip(fld_w, NCOORD);
        h = clip(fld_h, NCOORD);
        lv = clip(n_levels, NDEPTH);
        diff = int'(color_far) - int'(color_near);
        mag = (diff < 0 ? -diff : diff) + 1;
        st = mag / int'(lv);
        if (color_near > color_far)
        begin
            st = -st;
        end
        color_step = st[8:0];
        for (int i = 0; i < NSTARS; i++)
        begin
            star_x[i] = int'(draw(w) << 8);
            star_y[i] = int'(draw(h) << 8);
            star_z[i] = draw(lv);
        end
    endtask

    task automatic scroll_field(int xs, int ys);
        int unsigned w, h, lv, n;
        int f;
        w = clip(fld_w, NCOORD);
        h = clip(fld_h, NCOORD);
        lv = clip(n_levels, NDEPTH);
        n = (n_active > NSTARS) ? NSTARS : n_active;
        for (int i = 0; i < int'(n); i++)
        begin
            f = int'(star_z[i]) + 1;
            star_x[i] += f * xs;
            star_y[i] += f * ys;
            // wrap tests in fixed order, each wrap redraws the depth
            if (star_x[i] < 0)
            begin
                star_x[i] = int'((w - 1) << 8);
                star_z[i] = draw(lv);
            end
            if (star_y[i] < 0)
            begin
                star_y[i] = int'((h - 1) << 8);
                star_z[i] = draw(lv);
            end
            if (star_x[i] >= int'(w << 8))
            begin
                star_x[i] = 0;
                star_z[i] = draw(lv);
            end
            if (star_y[i] >= int'(h << 8))
            begin
                star_y[i] = 0;
                star_z[i] = draw(lv);
            end
        end
    endtask

    task automatic plot_star(int idx, int xo, int yo);
        pixel_t p;
        int px, py;
        int unsigned factor, col, n;
        n = (n_active > NSTARS) ? NSTARS : n_active;
        if (idx >= int'(n))
        begin
            return;
        end
        px = xo + (star_x[idx] >>> 8);
        py = yo + (star_y[idx] >>> 8);
        factor = clip(n_levels, NDEPTH) - 1 - star_z[idx];
        col = color_near + factor * unsigned'(int'(color_step));
        p.px = px[12:0];
        p.py = py[12:0];
        p.color = col[7:0];
        pixel_q.push_back(p);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            pixel_q.delete();
            color_step = '0;
            lfsr = LFSR_RESET;
            fld_w = 11'd320;
            fld_h = 11'd200;
            n_active = 11'd256;
            n_levels = 5'd8;
            color_near = 8'd255;
            color_far = 8'd0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_FIELD_WIDTH:  fld_w = pwdata[10:0];
                    REG_FIELD_HEIGHT: fld_h = pwdata[10:0];
                    REG_ACTIVE_STARS: n_active = pwdata[10:0];
                    REG_DEPTH_LEVELS: n_levels = pwdata[4:0];
                    REG_FIRST_COLOR:  color_near = pwdata[7:0];
                    REG_LAST_COLOR:   color_far = pwdata[7:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (pixel_q.size() == 0)
                begin
                    $display("%0t: unexpected word px=%0d py=%0d color=%0d",
                             $time, pixel_x, pixel_y, pixel_color);
                    errors++;
                end
                else
                begin
                    pixel_t e;
                    e = pixel_q.pop_front();
                    if (pixel_x !== e.px)
                    begin
                        $display("%0t: pixel_x expected %0d got %0d", $time, e.px, pixel_x);
                        errors++;
                    end
                    if (pixel_y !== e.py)
                    begin
                        $display("%0t: pixel_y expected %0d got %0d", $time, e.py, pixel_y);
                        errors++;
                    end
                    if (pixel_color !== e.color)
                    begin
                        $display("%0t: pixel_color expected %0d got %0d",
                                 $time, e.color, pixel_color);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (cmd)
                    CMD_SEED:   seed_field();
                    CMD_SCROLL: scroll_field(int'(x_step), int'(y_step));
                    CMD_PLOT:   plot_star(int'(star_index), int'(x_origin), int'(y_origin));
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: bench/tb_top.sv
// top of the starfield scroller bench: clock, reset, apb setup and command stimulus
// depends on sfps_pkg, starfield_parallax_scroller_unit and sfps_checker
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sfps_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] cmd = CMD_PLOT;
    logic signed [15:0] x_step = '0, y_step = '0;
    logic [9:0] star_index = '0;
    logic signed [11:0] x_origin = '0, y_origin = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [12:0] pixel_x, pixel_y;
    logic [7:0] pixel_color;

    int errors, pending;
    int cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;
    int cur_active = 256;

    always #4 clk = ~clk;

    starfield_parallax_scroller_unit uut (.*);

    sfps_checker chk (.*);

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver: random stall runs, some clean runs, and one long hold on request
    initial
    begin
        int run;
        bit level;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                // long hold so the output register fills and the input backs up
                hold_req = 1'b0;
                run = 400;
                level = 1'b1;
            end
            else
            begin
                run = $urandom_range(1, 20);
                level = ($urandom_range(0, 3) == 0) ? 1'b0 : $urandom_range(0, 1);
            end
            repeat (run)
            begin
                @(posedge clk);
                out_stall <= level;
            end
        end
    end

    // one apb write: setup phase, access phase, then idle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    // offer one command word and wait for it to be taken
    task automatic send(logic [1:0] c, logic signed [15:0] xs, logic signed [15:0] ys,
                        logic [9:0] idx, logic signed [11:0] xo, logic signed [11:0] yo);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        cmd <= c;
        x_step <= xs;
        y_step <= ys;
        star_index <= idx;
        x_origin <= xo;
        y_origin <= yo;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    // drain: all results in, then let a seed or scroll with no result finish
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        while (in_stall) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(int w, int h, int act, int lv, int c0, int c1);
        reg_write(REG_FIELD_WIDTH, w);
        reg_write(REG_FIELD_HEIGHT, h);
        reg_write(REG_ACTIVE_STARS, act);
        reg_write(REG_DEPTH_LEVELS, lv);
        reg_write(REG_FIRST_COLOR, c0);
        reg_write(REG_LAST_COLOR, c1);
        cur_active = (act > 1024) ? 1024 : act;
    endtask

    // random word: mostly plots of live stars, scrolls, a little noise
    task automatic random_word(bit big_steps);
        int r;
        logic [9:0] idx;
        logic signed [15:0] xs, ys;
        r = $urandom_range(0, 99);
        if (big_steps || $urandom_range(0, 3) == 0)
        begin
            xs = 16'($urandom);
            ys = 16'($urandom);
        end
        else
        begin
            xs = 16'($urandom_range(0, 1200) - 600);
            ys = 16'($urandom_range(0, 1200) - 600);
        end
        if (cur_active > 0 && $urandom_range(0, 99) < 85)
        begin
            idx = 10'($urandom_range(0, cur_active - 1));
        end
        else
        begin
            idx = 10'($urandom);
        end
        if (r < 5)
        begin
            send(CMD_UNUSED, 16'($urandom), 16'($urandom), 10'($urandom),
                 12'($urandom), 12'($urandom));
        end
        else if (r < 30)
        begin
            send(CMD_SCROLL, xs, ys, idx, 12'($urandom), 12'($urandom));
        end
        else
        begin
            send(CMD_PLOT, xs, ys, idx, 12'($urandom), 12'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: directed corners, no sender gaps
        gaps_on = 1'b0;
        send(CMD_SEED, 0, 0, 0, 0, 0);
        send(CMD_PLOT, 0, 0, 10'd0, -12'sd2048, -12'sd2048);
        send(CMD_PLOT, 0, 0, 10'd255, 12'sd2047, 12'sd2047);
        send(CMD_PLOT, 0, 0, 10'd256, 0, 0);
        send(CMD_PLOT, 0, 0, 10'd1023, 0, 0);
        send(CMD_UNUSED, 16'hffff, 16'hffff, 10'h3ff, -12'sd1, -12'sd1);
        send(CMD_SCROLL, 16'sd32767, 16'sd32767, 0, 0, 0);
        send(CMD_PLOT, 0, 0, 10'd1, 12'sd100, -12'sd100);
        send(CMD_SCROLL, -16'sd32768, -16'sd32768, 0, 0, 0);
        send(CMD_PLOT, 0, 0, 10'd2, 0, 0);
        send(CMD_SCROLL, 0, 0, 0, 0, 0);
        send(CMD_SCROLL, 16'sd256, -16'sd256, 0, 0, 0);
        send(CMD_PLOT, 0, 0, 10'd5, 12'sd7, 12'sd9);
        send(CMD_SCROLL, 16'sd1, 16'sd1, 0, 0, 0);
        send(CMD_PLOT, 0, 0, 10'd100, -12'sd5, 12'sd2047);
        send(CMD_PLOT, 0, 0, 10'd200, 12'sd2047, -12'sd2048);
        drain();

        // shrink levels so old depths overrun them, then degenerate field
        gaps_on = 1'b1;
        set_regs(1, 1, 4, 0, 0, 255);
        reg_write(REG_DEPTH_LEVELS, 2);
        repeat (3) send(CMD_PLOT, 0, 0, 10'($urandom_range(0, 3)),
                        12'($urandom), 12'($urandom));
        drain();
        reg_write(REG_DEPTH_LEVELS, 0);
        send(CMD_SEED, 0, 0, 0, 0, 0);
        repeat (60) random_word(1'b0);
        drain();

        // oversized registers, full table, equal colours
        set_regs(2047, 2047, 2047, 31, 255, 255);
        send(CMD_PLOT, 0, 0, 10'd1023, 12'sd2047, 12'sd2047);
        send(CMD_SCROLL, 16'sd200, -16'sd90, 0, 0, 0);
        repeat (15) send(CMD_PLOT, 0, 0, 10'($urandom), 12'($urandom), 12'($urandom));
        send(CMD_SCROLL, -16'sd50, 16'sd1000, 0, 0, 0);
        repeat (5) send(CMD_PLOT, 0, 0, 10'($urandom), 12'($urandom), 12'($urandom));
        drain();

        // mid-size field, long random run with a forced backup at its start
        set_regs(100, 60, 32, 5, 10, 200);
        send(CMD_SEED, 0, 0, 0, 0, 0);
        drain();
        hold_req = 1'b1;
        gaps_on = 1'b0;
        repeat (30) send(CMD_PLOT, 0, 0, 10'($urandom_range(0, 31)),
                         12'($urandom), 12'($urandom));
        gaps_on = 1'b1;
        repeat (90) random_word(1'b0);
        // no gaps for a stretch
        gaps_on = 1'b0;
        repeat (40) random_word(1'b1);
        gaps_on = 1'b1;
        drain();

        // zero active stars: every plot yields nothing
        set_regs(640, 480, 0, 16, 128, 3);
        repeat (8) random_word(1'b0);
        drain();

        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
